### rtl/core/rfec_pkg.sv
// Package for the RGB row FIR with edge clamp: shared constants, payload types
// and pipeline tag types. Has no dependencies of its own.
package rfec_pkg;

  // Kernel and pixel geometry.
  localparam int MAX_TAPS       = 15;
  localparam int COEF_FRAC_BITS = 14;
  localparam int COEF_W         = 16;
  localparam int CH_W           = 8;
  localparam int NCH            = 3;
  localparam int PIX_W          = CH_W * NCH;
  localparam int TAPCNT_W       = 4;
  localparam int HALF_W         = 3;
  localparam int POS_W          = 4;
  localparam int POS_MAX        = 15;
  localparam int COEF_ALL_W     = 240;

  // Arithmetic widths: an 8-bit unsigned pixel times a signed coefficient,
  // and the sum of all taps with headroom for the rounding offset.
  localparam int PROD_W      = CH_W + 1 + COEF_W;
  localparam int TREE_LEVELS = $clog2(MAX_TAPS);
  localparam int TREE_LEAVES = 1 << TREE_LEVELS;
  localparam int SUM_W       = PROD_W + TREE_LEVELS + 1;

  // Result queue.
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_0_3  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_4_7  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_8_11 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_12_14 = 3'd4;

  typedef struct packed {
    logic             row_end_in;
    logic [PIX_W-1:0] pixel_in;
  } pix_in_t;

  typedef struct packed {
    logic             last_of_run;
    logic             row_end_out;
    logic [PIX_W-1:0] pixel_out;
  } pix_out_t;

  // Control that travels alongside the data through the pipeline.
  typedef struct packed {
    logic valid;
    logic row_end;
    logic last;
  } tag_t;

  typedef logic [NCH-1:0][PROD_W-1:0] prod_vec_t;
  typedef logic [NCH-1:0][SUM_W-1:0]  sum_vec_t;

endpackage

### rtl/core/rfec_cell.sv
// One cell of the pixel window: holds the pixel of one age and registers its
// per-channel product with the coefficient that lines up with that age.
// Depends on rfec_pkg.
module rfec_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           fill_i,
  input  logic [rfec_pkg::PIX_W-1:0]     fill_px_i,
  input  logic [rfec_pkg::PIX_W-1:0]     prev_px_i,
  input  logic signed [rfec_pkg::COEF_W-1:0] coef_i,
  output logic [rfec_pkg::PIX_W-1:0]     px_o,
  output rfec_pkg::prod_vec_t            prod_o
);
  import rfec_pkg::*;

  logic [PIX_W-1:0] px_q;
  prod_vec_t        prod_q;

  // Shift from the neighbor, or take the row's first pixel everywhere.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
    end else if (adv_i) begin
      px_q <= fill_i ? fill_px_i : prev_px_i;
    end
  end

  // One small multiplier per channel, registered.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NCH; c++) begin
      prod_q[c] <= PROD_W'($signed({1'b0, px_q[c*CH_W +: CH_W]}) * coef_i);
    end
  end

  assign px_o   = px_q;
  assign prod_o = prod_q;

endmodule

### rtl/core/rfec_adder_tree.sv
// Registered pairwise adder tree that sums the products of all cells per
// channel, with the pipeline tag delayed to match. Depends on rfec_pkg.
module rfec_adder_tree (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rfec_pkg::prod_vec_t prod_i [rfec_pkg::MAX_TAPS],
  input  rfec_pkg::tag_t      tag_i,
  output rfec_pkg::sum_vec_t  sum_o,
  output rfec_pkg::tag_t      tag_o
);
  import rfec_pkg::*;

  logic signed [SUM_W-1:0] leaf  [NCH][TREE_LEAVES];
  logic signed [SUM_W-1:0] lvl_q [TREE_LEVELS][NCH][TREE_LEAVES];
  tag_t                    tag_q [TREE_LEVELS];

  // Leaves: sign-extended products, padded with zero.
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      for (int k = 0; k < TREE_LEAVES; k++) begin
        if (k < MAX_TAPS) begin
          leaf[c][k] = SUM_W'($signed(prod_i[k][c]));
        end else begin
          leaf[c][k] = '0;
        end
      end
    end
  end

  // One register level per halving of the operand count.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < TREE_LEVELS; l++) begin
      for (int c = 0; c < NCH; c++) begin
        for (int k = 0; k < TREE_LEAVES; k++) begin
          if (k < (TREE_LEAVES >> (l + 1))) begin
            if (l == 0) begin
              lvl_q[l][c][k] <= leaf[c][2*k] + leaf[c][2*k+1];
            end else begin
              lvl_q[l][c][k] <= lvl_q[l-1][c][2*k] + lvl_q[l-1][c][2*k+1];
            end
          end else begin
            lvl_q[l][c][k] <= '0;
          end
        end
      end
    end
  end

  // Tag delay line alongside the tree.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < TREE_LEVELS; l++) begin
        tag_q[l] <= '0;
      end
    end else begin
      tag_q[0] <= tag_i;
      for (int l = 1; l < TREE_LEVELS; l++) begin
        tag_q[l] <= tag_q[l-1];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum_o[c] = lvl_q[TREE_LEVELS-1][c][0];
    end
  end

  assign tag_o = tag_q[TREE_LEVELS-1];

endmodule

### rtl/core/rfec_out_fifo.sv
// Result queue between the filter pipeline and the output channel. The writer
// never overruns it because requests are issued only against free credits.
// Depends on rfec_pkg.
module rfec_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  input  rfec_pkg::pix_out_t wr_data_i,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output rfec_pkg::pix_out_t rd_data_o
);
  import rfec_pkg::*;

  pix_out_t           mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               rd_fire;

  assign rd_valid_o = (cnt_q != '0);
  assign rd_fire    = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_valid_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (rd_fire) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_q + CNT_W'(wr_valid_i) - CNT_W'(rd_fire);
    end
  end

endmodule

### rtl/core/rgb_row_fir_edge_clamp_unit.sv
// Horizontal FIR over packed RGB pixels with edge replication at row ends.
// Top level: request sequencer, window of cells, adder tree, rounding, queue.
//
// Usage: pixels enter on in_req_i under in_valid_i/in_ready_o, one per clock
// while in_ready_o is high, with row_end_in set on the last pixel of each row.
// Filtered pixels leave on out_req_o under out_valid_o/out_ready_i. Output
// column x is produced once pixel x + tap_count/2 has arrived; the row's last
// pixel triggers the remaining outputs of the row, which the sequencer creates
// by replaying that pixel into the window tap_count/2 times. During that run
// the input is held off. An accepted request passes through the request
// register, window cell, product, four adder-tree levels, rounding and the
// result queue. The sustained rate is one pixel per cycle while in_ready_o is
// high, set by the window shifting once per cycle. A 16-entry result queue
// decouples the receiver: requests that produce a result are issued only while
// a queue credit is free, so a stalled receiver stops the input after the
// queue fills and no result is lost. Reset clears the row position, the
// pipeline and the queue, and loads tap_count = 1 with tap 0 = 1.0
// (pass-through). Configuration writes take effect at once and belong to
// idle periods.
module rgb_row_fir_edge_clamp_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rfec_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rfec_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rfec_pkg::pix_in_t                 in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rfec_pkg::pix_out_t                out_req_o
);
  import rfec_pkg::*;

  // Request driven into the window each cycle.
  typedef struct packed {
    logic             valid;
    logic             fill;
    logic             emit;
    logic             row_end;
    logic             last;
    logic [PIX_W-1:0] px;
  } cmd_t;

  // Configuration registers.
  logic [TAPCNT_W-1:0]   tap_count_q;
  logic [CFG_DATA_W-1:0] coef03_q, coef47_q, coef811_q;
  logic [47:0]           coef1214_q;

  // Sequencer state.
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              rep_q, rep_d;
  logic [HALF_W-1:0] rep_k_q, rep_k_d;
  logic [HALF_W-1:0] first_q, first_d;
  logic [PIX_W-1:0]  last_px_q, last_px_d;
  logic [CNT_W-1:0]  credit_q;
  cmd_t              cmd_d, cmd_q;

  logic [TAPCNT_W-1:0]   taps;
  logic [HALF_W-1:0]     half;
  logic [COEF_ALL_W-1:0] coef_all;
  logic                  credit_ok;
  logic                  in_fire, out_fire;
  logic                  rep_emit;
  logic [POS_W-1:0]      half_ext;
  logic [HALF_W-1:0]     dmin;

  logic [PIX_W-1:0]          cell_px   [MAX_TAPS];
  prod_vec_t                 cell_prod [MAX_TAPS];
  logic signed [COEF_W-1:0]  cell_coef [MAX_TAPS];

  tag_t     tag_s1_q, tag_s2_q, tree_tag, res_tag_q;
  sum_vec_t tree_sum;
  pix_out_t res_q, res_d;

  // Configuration write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAPCNT_W'(1);
      coef03_q    <= CFG_DATA_W'(16384);
      coef47_q    <= '0;
      coef811_q   <= '0;
      coef1214_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TAP_COUNT:  tap_count_q <= cfg_data_i[TAPCNT_W-1:0];
        CFG_COEF_0_3:   coef03_q    <= cfg_data_i;
        CFG_COEF_4_7:   coef47_q    <= cfg_data_i;
        CFG_COEF_8_11:  coef811_q   <= cfg_data_i;
        CFG_COEF_12_14: coef1214_q  <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  assign taps     = (32'(tap_count_q) > MAX_TAPS) ? TAPCNT_W'(MAX_TAPS) : tap_count_q;
  assign half     = taps[TAPCNT_W-1:1];
  assign half_ext = POS_W'(half);
  assign coef_all = {coef1214_q, coef811_q, coef47_q, coef03_q};

  // Cell j holds the pixel of age j; for the centered output it meets
  // tap 2*half - j, and no tap where that index falls outside the kernel.
  always_comb begin
    for (int j = 0; j < MAX_TAPS; j++) begin
      cell_coef[j] = '0;
      if (j <= 2 * int'(half) && (2 * int'(half) - j) < int'(taps)) begin
        cell_coef[j] = coef_all[(2 * int'(half) - j) * COEF_W +: COEF_W];
      end
    end
  end

  assign credit_ok = (credit_q < CNT_W'(FIFO_DEPTH));
  assign in_ready_o = !rep_q && credit_ok;
  assign in_fire    = in_valid_i && in_ready_o;
  assign rep_emit   = (rep_k_q >= first_q);
  assign dmin       = (pos_q < half_ext) ? pos_q[HALF_W-1:0] : half;

  // Request sequencer: accepted pixels, then replays of the row's last pixel
  // that flush the outputs still owed at the row end.
  always_comb begin
    cmd_d     = '0;
    pos_d     = pos_q;
    rep_d     = rep_q;
    rep_k_d   = rep_k_q;
    first_d   = first_q;
    last_px_d = last_px_q;
    if (rep_q) begin
      if (!rep_emit || credit_ok) begin
        cmd_d.valid   = 1'b1;
        cmd_d.px      = last_px_q;
        cmd_d.emit    = rep_emit;
        cmd_d.row_end = (rep_k_q == half);
        cmd_d.last    = (rep_k_q == half);
        rep_k_d       = rep_k_q + HALF_W'(1);
        if (rep_k_q == half) begin
          rep_d = 1'b0;
        end
      end
    end else if (in_fire) begin
      cmd_d.valid   = 1'b1;
      cmd_d.px      = in_req_i.pixel_in;
      cmd_d.fill    = (pos_q == '0);
      cmd_d.emit    = (pos_q >= half_ext);
      cmd_d.row_end = in_req_i.row_end_in && (half == '0);
      cmd_d.last    = !in_req_i.row_end_in || (half == '0);
      if (in_req_i.row_end_in) begin
        pos_d     = '0;
        last_px_d = in_req_i.pixel_in;
        if (half != '0) begin
          rep_d   = 1'b1;
          rep_k_d = HALF_W'(1);
          first_d = half - dmin;
        end
      end else if (32'(pos_q) < POS_MAX) begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  assign out_fire = out_valid_o && out_ready_i;

  // Sequencer registers and queue credits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      rep_q    <= 1'b0;
      rep_k_q  <= '0;
      first_q  <= '0;
      cmd_q    <= '0;
      credit_q <= '0;
    end else begin
      pos_q    <= pos_d;
      rep_q    <= rep_d;
      rep_k_q  <= rep_k_d;
      first_q  <= first_d;
      cmd_q    <= cmd_d;
      credit_q <= credit_q + CNT_W'(cmd_d.valid && cmd_d.emit) - CNT_W'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    last_px_q <= last_px_d;
  end

  // Chain of window cells.
  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    rfec_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (cmd_q.valid),
      .fill_i    (cmd_q.fill),
      .fill_px_i (cmd_q.px),
      .prev_px_i ((j == 0) ? cmd_q.px : cell_px[(j == 0) ? 0 : j - 1]),
      .coef_i    (cell_coef[j]),
      .px_o      (cell_px[j]),
      .prod_o    (cell_prod[j])
    );
  end

  // Tag follows the window and product registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_s1_q <= '0;
      tag_s2_q <= '0;
    end else begin
      tag_s1_q <= '{valid: cmd_q.valid && cmd_q.emit, row_end: cmd_q.row_end,
                    last: cmd_q.last};
      tag_s2_q <= tag_s1_q;
    end
  end

  rfec_adder_tree u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .prod_i (cell_prod),
    .tag_i  (tag_s2_q),
    .sum_o  (tree_sum),
    .tag_o  (tree_tag)
  );

  // Round by adding one half, floor, and saturate each channel to 0..255.
  always_comb begin
    logic signed [SUM_W-1:0] r;
    logic signed [SUM_W-1:0] s;
    res_d             = '0;
    res_d.row_end_out = tree_tag.row_end;
    res_d.last_of_run = tree_tag.last;
    for (int c = 0; c < NCH; c++) begin
      r = $signed(tree_sum[c]) + SUM_W'(1 << (COEF_FRAC_BITS - 1));
      s = r >>> COEF_FRAC_BITS;
      if (r < 0) begin
        res_d.pixel_out[c*CH_W +: CH_W] = '0;
      end else if (s > SUM_W'(255)) begin
        res_d.pixel_out[c*CH_W +: CH_W] = '1;
      end else begin
        res_d.pixel_out[c*CH_W +: CH_W] = s[CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_tag_q <= '0;
    end else begin
      res_tag_q <= tree_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  rfec_out_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (res_tag_q.valid),
    .wr_data_i  (res_q),
    .rd_valid_o (out_valid_o),
    .rd_ready_i (out_ready_i),
    .rd_data_o  (out_req_o)
  );

endmodule

### test/tb_rgb_row_fir_edge_clamp_unit.sv
// Testbench for rgb_row_fir_edge_clamp_unit: random rows of pixels under several kernels,
// checked against a built-in predictor of the filter. Depends on rfec_pkg and the unit.
`timescale 1ns / 1ps
module tb_rgb_row_fir_edge_clamp_unit;
  import rfec_pkg::*;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  pix_in_t in_req_i;
  pix_out_t out_req_o;

  rgb_row_fir_edge_clamp_unit dut (.*);

  // Predictor state: configuration and pixel window, newest first.
  logic [3:0]           kern_taps;
  logic [63:0]          coef_reg [4];
  logic [PIX_W-1:0]     win [MAX_TAPS];
  int unsigned          col_pos;

  pix_in_t  pending_px [$];
  pix_out_t expected_px [$];
  int       errors;
  int       rx_phase;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("tb_rgb_row_fir_edge_clamp_unit NOT OK");
    $finish;
  end

  function automatic logic signed [16:0] coef_at(int i);
    logic [15:0] raw;
    if (i >= 15) return 0;
    raw = coef_reg[i / 4][(i % 4) * 16 +: 16];
    return $signed(raw);
  endfunction

  function automatic logic [7:0] round_clamp(longint acc);
    longint v;
    v = acc + (64'sd1 <<< (COEF_FRAC_BITS - 1));
    if (v < 0) return 8'd0;
    v = v >>> COEF_FRAC_BITS;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [PIX_W-1:0] fir_at(int d, int taps, int half);
    longint acc [3];
    logic [PIX_W-1:0] px;
    int age;
    for (int c = 0; c < 3; c++) acc[c] = 0;
    for (int i = 0; i < taps; i++) begin
      age = (d + half >= i) ? d + half - i : 0;
      if (age >= MAX_TAPS) age = MAX_TAPS - 1;
      px = win[age];
      for (int c = 0; c < 3; c++) acc[c] += longint'(px[8*c +: 8]) * longint'(coef_at(i));
    end
    return {round_clamp(acc[2]), round_clamp(acc[1]), round_clamp(acc[0])};
  endfunction

  // Advance the predictor by one accepted request and queue its results.
  task automatic predict_pixel(pix_in_t r);
    int taps, half, d;
    pix_out_t o;
    taps = (kern_taps > MAX_TAPS) ? MAX_TAPS : kern_taps;
    half = taps / 2;
    if (col_pos == 0) begin
      for (int i = 0; i < MAX_TAPS; i++) win[i] = r.pixel_in;
    end else begin
      for (int i = MAX_TAPS - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = r.pixel_in;
    end
    if (r.row_end_in) begin
      d = (col_pos < half) ? col_pos : half;
      while (1) begin
        o.pixel_out = fir_at(d, taps, half);
        o.row_end_out = (d == 0);
        o.last_of_run = (d == 0);
        expected_px.push_back(o);
        if (d == 0) break;
        d--;
      end
      col_pos = 0;
    end else begin
      if (col_pos >= half) begin
        o.pixel_out = fir_at(half, taps, half);
        o.row_end_out = 1'b0;
        o.last_of_run = 1'b1;
        expected_px.push_back(o);
      end
      col_pos = (col_pos < 15) ? col_pos + 1 : 15;
    end
  endtask

  // Driver: bursts of requests with random gaps.
  int burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_pixel(in_req_i);
        void'(pending_px.pop_front());
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_px.size() > 0) begin
          in_valid_i <= 1'b1;
          in_req_i <= pending_px[0];
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall pattern and comparison against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    pix_out_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_phase = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_px.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_req_o);
          errors++;
        end else begin
          e = expected_px.pop_front();
          if (e.pixel_out !== out_req_o.pixel_out)
            begin $display("%0t: pixel_out exp %h got %h", $time, e.pixel_out,
              out_req_o.pixel_out); errors++; end
          if (e.row_end_out !== out_req_o.row_end_out)
            begin $display("%0t: row_end_out exp %b got %b", $time, e.row_end_out,
              out_req_o.row_end_out); errors++; end
          if (e.last_of_run !== out_req_o.last_of_run)
            begin $display("%0t: last_of_run exp %b got %b", $time, e.last_of_run,
              out_req_o.last_of_run); errors++; end
        end
      end
      // Phases: full speed, periodic stall, random stall, long stall.
      rx_phase = (rx_phase + 1) % 400;
      if (rx_phase < 100) out_ready_i <= 1'b1;
      else if (rx_phase < 200) out_ready_i <= (rx_phase % 3) != 0;
      else if (rx_phase < 300) out_ready_i <= $urandom_range(0, 1);
      else out_ready_i <= (rx_phase % 50) > 30;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TAP_COUNT:  kern_taps = val[3:0];
      CFG_COEF_0_3:   coef_reg[0] = val;
      CFG_COEF_4_7:   coef_reg[1] = val;
      CFG_COEF_8_11:  coef_reg[2] = val;
      CFG_COEF_12_14: coef_reg[3] = {16'd0, val[47:0]};
      default: ;
    endcase
  endtask

  // Wait until all requests are accepted and all results have arrived.
  task automatic drain();
    while (pending_px.size() > 0 || in_valid_i || expected_px.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_coef(int mode);
    case (mode)
      0: return 16'h4000;
      1: return 16'h7fff;
      2: return 16'h8000;
      default: return 16'($urandom_range(0, 16'h1800) - 16'h0400);
    endcase
  endfunction

  // Queue one row of random pixels ending with the row-end flag.
  task automatic add_row(int len);
    pix_in_t r;
    for (int i = 0; i < len; i++) begin
      r.pixel_in = 24'($urandom);
      r.row_end_in = (i == len - 1);
      pending_px.push_back(r);
    end
  endtask

  initial begin
    pix_in_t r;
    logic [63:0] v [4];
    int mode;
    errors = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    kern_taps = 4'd1;
    coef_reg[0] = 64'd16384;
    for (int i = 1; i < 4; i++) coef_reg[i] = '0;
    for (int i = 0; i < MAX_TAPS; i++) win[i] = '0;
    col_pos = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows under the reset pass-through kernel: extremes and a one-pixel row.
    r.pixel_in = 24'h000000; r.row_end_in = 1'b0; pending_px.push_back(r);
    r.pixel_in = 24'hffffff; pending_px.push_back(r);
    r.pixel_in = 24'h00ff00; r.row_end_in = 1'b1; pending_px.push_back(r);
    r.pixel_in = 24'hff00ff; pending_px.push_back(r);
    drain();

    // Full-width kernel with maximal positive taps saturates; long row passes position 15.
    write_reg(CFG_TAP_COUNT, 4'd15);
    for (int i = 0; i < 4; i++) write_reg(CFG_IDX_W'(i + 1), {4{16'h7fff}});
    add_row(3);
    add_row(18);
    drain();

    // Negative taps clamp to zero; tap count zero; even count.
    for (int i = 0; i < 4; i++) write_reg(CFG_IDX_W'(i + 1), {4{16'h8000}});
    add_row(6);
    drain();
    write_reg(CFG_TAP_COUNT, 4'd0);
    add_row(4);
    drain();
    write_reg(CFG_TAP_COUNT, 4'd4);
    write_reg(CFG_COEF_0_3, {16'h1000, 16'h1000, 16'h1000, 16'h1000});
    add_row(5);
    drain();

    // Random phases: new kernel, then rows of random length, mostly short.
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_TAP_COUNT, (ph == 9) ? 4'd15 : 4'($urandom_range(0, 15)));
      for (int k = 0; k < 4; k++) begin
        mode = $urandom_range(0, 5);
        for (int j = 0; j < 4; j++) v[k][16*j +: 16] = rand_coef(mode);
        if ($urandom_range(0, 7) == 0) v[k] = {$urandom, $urandom};
        write_reg(CFG_IDX_W'(k + 1), v[k]);
      end
      for (int n = 0; n < 3; n++)
        add_row(($urandom_range(0, 5) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8));
      drain();
    end

    if (errors == 0) begin
      $display("tb_rgb_row_fir_edge_clamp_unit OK");
    end else begin
      $display("tb_rgb_row_fir_edge_clamp_unit NOT OK");
    end
    $finish;
  end

endmodule
